// ----- rtl/core/dsob_pkg.sv -----
`timescale 1ns / 1ps

package dsob_pkg;

  localparam int unsigned MODES    = 64;
  localparam int unsigned MODE_AW  = (MODES > 1) ? $clog2(MODES) : 1;
  localparam int unsigned LUT_AW   = 18;
  localparam int unsigned QTR_W    = LUT_AW - 2;
  localparam int unsigned P_W      = QTR_W + 1;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [23:0] ENV_ONE     = 24'h80_0000;
  localparam logic [23:0] ENV_MAX     = 24'hFF_FFFF;
  localparam logic [7:0]  WRAP_MAX    = 8'd255;
  localparam logic [16:0] ATTACK_ONE  = 17'h1_0000;
  localparam logic [16:0] SINE_MAX    = 17'd131071;
  localparam int unsigned VOL_SHIFT   = 14;
  localparam int unsigned ACC_W       = 40;
  localparam logic [2:0]  SERIES_LAST = 3'd5;

  localparam int unsigned FQ_DEPTH = 2;
  localparam int unsigned FQ_AW    = 1;

  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_DECAY = 3'd1;
  localparam logic [2:0] OP_TICK  = 3'd2;
  localparam logic [2:0] OP_START = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;

  localparam logic [2:0] CFG_VOLUME   = 3'd0;
  localparam logic [2:0] CFG_ATT_LEN  = 3'd1;
  localparam logic [2:0] CFG_ATT_RCP  = 3'd2;
  localparam logic [2:0] CFG_DURATION = 3'd3;
  localparam logic [2:0] CFG_GAIN_BND = 3'd4;

  typedef enum logic [2:0] {
    CMD_LOAD, CMD_DECAY, CMD_TICK, CMD_START, CMD_STOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [MODE_AW-1:0] idx;
    logic [31:0]        inc;
    logic [23:0]        gain;
    logic [23:0]        decay;
    logic [17:0]        bend;
    logic [17:0]        recip;
  } cmd_t;

  typedef struct packed {
    logic [15:0] volume;
    logic [23:0] attack_periods;
    logic [31:0] attack_recip;
    logic [31:0] duration;
    logic        gain_by_bend;
  } cfg_t;

  // The nested sine series divides by 156, 110, 72, 42, 20 and 6, innermost term first.
  // Each divisor d is replaced by a multiplication with ceil(2^s / d) and a shift by s,
  // where s is 32 plus the bits of d; this gives the exact quotient of any 32-bit dividend.
  function automatic logic [32:0] series_magic(input logic [2:0] k);
    logic [63:0] m;
    case (k)
      3'd0:    m = ((64'd1 << 40) + 64'd155) / 64'd156;
      3'd1:    m = ((64'd1 << 39) + 64'd109) / 64'd110;
      3'd2:    m = ((64'd1 << 39) + 64'd71) / 64'd72;
      3'd3:    m = ((64'd1 << 38) + 64'd41) / 64'd42;
      3'd4:    m = ((64'd1 << 37) + 64'd19) / 64'd20;
      default: m = ((64'd1 << 35) + 64'd5) / 64'd6;
    endcase
    return m[32:0];
  endfunction

  function automatic logic [5:0] series_shift(input logic [2:0] k);
    logic [5:0] s;
    case (k)
      3'd0:    s = 6'd40;
      3'd1:    s = 6'd39;
      3'd2:    s = 6'd39;
      3'd3:    s = 6'd38;
      3'd4:    s = 6'd37;
      default: s = 6'd35;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/core/decaying_sine_oscillator_bank_unit.sv -----
// A tick passes through the queue; while playing, the back end then visits every slot and runs
// a sine lookup for each valid mode in range (a skipped mode needs none) and a second one for a
// mode with its attack open. Both go to the shared sine unit; an idle tick answers with zero.
// Other commands are taken in the back end's idle state; a two-entry queue buffers them.
// The receiver cannot stall: each result stands for one cycle under result_strobe_o.
// Reset is asynchronous; no memory clearing pass is needed.
`timescale 1ns / 1ps

module decaying_sine_oscillator_bank_unit
  import dsob_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode_i,
  input  logic [5:0]         mode_index_i,
  input  logic [31:0]        increment_i,
  input  logic signed [23:0] gain_i,
  input  logic [23:0]        decay_i,
  input  logic [17:0]        bend_mult_i,
  input  logic [17:0]        bend_recip_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  output logic               result_strobe_o,
  output logic signed [23:0] sample_o,
  output logic               voice_active_o
);

  cfg_t cfg_q;
  logic head_valid;
  cmd_t head;
  logic pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{volume: 16'd32768, attack_periods: 24'd0, attack_recip: 32'd0,
                 duration: 32'd0, gain_by_bend: 1'b0};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_VOLUME:   cfg_q.volume         <= cfg_wdata_i[15:0];
        CFG_ATT_LEN:  cfg_q.attack_periods <= cfg_wdata_i[23:0];
        CFG_ATT_RCP:  cfg_q.attack_recip   <= cfg_wdata_i;
        CFG_DURATION: cfg_q.duration       <= cfg_wdata_i;
        CFG_GAIN_BND: cfg_q.gain_by_bend   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  dsob_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .mode_index_i (mode_index_i),
    .increment_i  (increment_i),
    .gain_i       (gain_i),
    .decay_i      (decay_i),
    .bend_mult_i  (bend_mult_i),
    .bend_recip_i (bend_recip_i),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  dsob_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .cfg_i          (cfg_q),
    .strobe_o       (result_strobe_o),
    .sample_o       (sample_o),
    .voice_active_o (voice_active_o)
  );

endmodule

// ----- rtl/core/dsob_sine.sv -----
`timescale 1ns / 1ps

module dsob_sine
  import dsob_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [P_W-1:0] p_i,
  output logic           done_o,
  output logic [16:0]    value_o
);

  typedef enum logic [6:0] {
    SN_IDLE = 7'b0000001,
    SN_X    = 7'b0000010,
    SN_X2   = 7'b0000100,
    SN_MUL  = 7'b0001000,
    SN_DIV  = 7'b0010000,
    SN_S    = 7'b0100000,
    SN_RND  = 7'b1000000
  } sn_state_e;

  sn_state_e      state_q;
  logic [P_W-1:0] p_q;
  logic [30:0]    x_q;
  logic [31:0]    x2_q;
  logic [30:0]    acc_q;
  logic [31:0]    t_q;
  logic [2:0]     k_q;
  logic [30:0]    s_q;
  logic           done_q;
  logic [16:0]    value_q;

  logic [P_W+30:0] x_prod;
  logic [P_W+30:0] x_full;
  logic [61:0]     x2_prod;
  logic [62:0]     t_prod;
  logic [61:0]     s_prod;
  logic [32:0]     magic;
  logic [5:0]      shamt;
  logic [64:0]     q_prod;
  logic [64:0]     q_full;
  logic [31:0]     rnd_sum;
  logic [18:0]     rnd_v;

  assign x_prod   = p_q * HALF_PI_Q30;
  assign x_full   = x_prod >> QTR_W;
  assign x2_prod  = x_q * x_q;
  assign t_prod   = x2_q * acc_q;
  assign s_prod   = x_q * acc_q;
  assign magic    = series_magic(k_q);
  assign shamt    = series_shift(k_q);
  assign q_prod   = t_q * magic;
  assign q_full   = q_prod >> shamt;
  assign rnd_sum  = {1'b0, s_q} + 32'd4096;
  assign rnd_v    = rnd_sum[31:13];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SN_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        SN_IDLE: begin
          if (start_i) state_q <= SN_X;
        end
        SN_X:   state_q <= SN_X2;
        SN_X2:  state_q <= SN_MUL;
        SN_MUL: state_q <= SN_DIV;
        SN_DIV: state_q <= (k_q == SERIES_LAST) ? SN_S : SN_MUL;
        SN_S:   state_q <= SN_RND;
        SN_RND: begin
          done_q  <= 1'b1;
          state_q <= SN_IDLE;
        end
        default: state_q <= SN_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SN_IDLE: begin
        if (start_i) p_q <= p_i;
      end
      SN_X: begin
        x_q   <= x_full[30:0];
        acc_q <= Q30_ONE;
        k_q   <= 3'd0;
      end
      SN_X2:  x2_q <= x2_prod[61:30];
      SN_MUL: t_q <= t_prod[61:30];
      SN_DIV: begin
        acc_q <= Q30_ONE - q_full[30:0];
        k_q   <= k_q + 3'd1;
      end
      SN_S: s_q <= s_prod[60:30];
      SN_RND: value_q <= (rnd_v > {2'b00, SINE_MAX}) ? SINE_MAX : rnd_v[16:0];
      default: ;
    endcase
  end

  assign done_o  = done_q;
  assign value_o = value_q;

endmodule

// ----- rtl/core/dsob_front.sv -----
`timescale 1ns / 1ps

module dsob_front
  import dsob_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode_i,
  input  logic [5:0]  mode_index_i,
  input  logic [31:0] increment_i,
  input  logic [23:0] gain_i,
  input  logic [23:0] decay_i,
  input  logic [17:0] bend_mult_i,
  input  logic [17:0] bend_recip_i,
  input  logic        pop_i,
  output logic        head_valid_o,
  output cmd_t        head_o
);

  cmd_t             fifo_q [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_ptr_q;
  logic [FQ_AW-1:0] rd_ptr_q;
  logic [FQ_AW:0]   count_q;

  logic      keep;
  logic      push;
  logic      pop;
  cmd_kind_e kind;
  logic      idx_ok;

  assign idx_ok = (32'(mode_index_i) < MODES);

  // Unknown opcodes and slots beyond the bank are dropped here.
  always_comb begin
    keep = 1'b1;
    kind = CMD_TICK;
    case (opcode_i)
      OP_LOAD: begin
        kind = CMD_LOAD;
        keep = idx_ok;
      end
      OP_DECAY: begin
        kind = CMD_DECAY;
        keep = idx_ok;
      end
      OP_TICK:  kind = CMD_TICK;
      OP_START: kind = CMD_START;
      OP_STOP:  kind = CMD_STOP;
      default:  keep = 1'b0;
    endcase
  end

  assign busy         = (count_q == (FQ_AW + 1)'(FQ_DEPTH));
  assign push         = start && !busy && keep;
  assign head_valid_o = (count_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{kind:  kind,
                            idx:   MODE_AW'(mode_index_i),
                            inc:   increment_i,
                            gain:  gain_i,
                            decay: decay_i,
                            bend:  bend_mult_i,
                            recip: bend_recip_i};
    end
  end

endmodule

// ----- rtl/core/dsob_back.sv -----
`timescale 1ns / 1ps

module dsob_back
  import dsob_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  cmd_t               head_i,
  output logic               pop_o,
  input  cfg_t               cfg_i,
  output logic               strobe_o,
  output logic signed [23:0] sample_o,
  output logic               voice_active_o
);

  typedef struct packed {
    logic [31:0] inc;
    logic [23:0] gain;
    logic [31:0] phase;
    logic [23:0] env;
    logic [7:0]  wraps;
  } mode_word_t;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_RD     = 14'b00000000000010,
    ST_BEND   = 14'b00000000000100,
    ST_CHK    = 14'b00000000001000,
    ST_SIN    = 14'b00000000010000,
    ST_RATIO  = 14'b00000000100000,
    ST_ASTART = 14'b00000001000000,
    ST_AWAIT  = 14'b00000010000000,
    ST_W2     = 14'b00000100000000,
    ST_WMUL   = 14'b00001000000000,
    ST_TERM   = 14'b00010000000000,
    ST_NEXT   = 14'b00100000000000,
    ST_VOL    = 14'b01000000000000,
    ST_OUT    = 14'b10000000000000
  } st_state_e;

  mode_word_t mode_mem  [MODES];
  logic [23:0] decay_mem [MODES];

  st_state_e          state_q;
  logic [MODE_AW-1:0] m_q;
  mode_word_t         rd_q;
  logic [23:0]        rd_dec_q;
  logic [MODES-1:0]   valid_q;
  logic               playing_q;
  logic [31:0]        played_q;
  logic [17:0]        bend_q;
  logic [17:0]        recip_q;
  logic [33:0]        bent_q;
  logic [25:0]        gm_q;
  logic               g_neg_q;
  logic               val_neg_q;
  logic [16:0]        sm_q;
  logic [26:0]        ge_q;
  logic [16:0]        ratio_q;
  logic [16:0]        w_q;
  logic [16:0]        w2_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [ACC_W+1:0]   smag_q;
  logic               sneg_q;
  logic               strobe_q;
  logic [23:0]        sample_q;
  logic               active_q;

  logic               sin_start;
  logic [P_W-1:0]     sin_p;
  logic               sin_done;
  logic [16:0]        sin_value;

  logic               mem_we;
  logic [MODE_AW-1:0] mem_addr;
  mode_word_t         mem_wdata;
  logic               dec_we;

  logic [49:0]        bent_prod;
  logic [LUT_AW-1:0]  lut_idx;
  logic [1:0]         quad;
  logic [QTR_W-1:0]   rem_idx;
  logic [P_W-1:0]     p_main;
  logic [QTR_W+16:0]  att_sh;
  logic [P_W-1:0]     p_att;
  logic [23:0]        g_abs;
  logic [41:0]        gb_prod;
  logic [49:0]        ge_prod;
  logic [23:0]        pos;
  logic [55:0]        ratio_prod;
  logic [39:0]        ratio_full;
  logic [33:0]        w2_prod;
  logic [33:0]        wm_prod;
  logic [43:0]        term_prod;
  logic [26:0]        term;
  logic [32:0]        phase_sum;
  logic [7:0]         wraps_new;
  logic [47:0]        env_prod;
  logic [24:0]        env_full;
  logic [23:0]        env_new;
  logic [ACC_W-1:0]   acc_abs;
  logic [ACC_W+15:0]  vol_prod;
  logic [31:0]        played_inc;
  logic               attack_on;

  dsob_sine u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sin_start),
    .p_i     (sin_p),
    .done_o  (sin_done),
    .value_o (sin_value)
  );

  assign bent_prod  = rd_q.inc * bend_q;
  assign lut_idx    = rd_q.phase[31 -: LUT_AW];
  assign quad       = lut_idx[LUT_AW-1 -: 2];
  assign rem_idx    = lut_idx[QTR_W-1:0];
  assign p_main     = quad[0] ? ((P_W'(1) << QTR_W) - P_W'(rem_idx)) : P_W'(rem_idx);
  assign att_sh     = ratio_q << QTR_W;
  assign p_att      = P_W'(att_sh >> 16);
  assign g_abs      = rd_q.gain[23] ? (24'd0 - rd_q.gain) : rd_q.gain;
  assign gb_prod    = g_abs * recip_q;
  assign ge_prod    = gm_q * rd_q.env;
  assign pos        = {rd_q.wraps, rd_q.phase[31:16]};
  assign ratio_prod = pos * cfg_i.attack_recip;
  assign ratio_full = ratio_prod[55:16];
  assign w2_prod    = w_q * w_q;
  assign wm_prod    = sm_q * w2_q;
  assign term_prod  = ge_q * sm_q;
  assign term       = term_prod[43:17];
  assign phase_sum  = {1'b0, rd_q.phase} + {1'b0, bent_q[31:0]};
  assign wraps_new  = (phase_sum[32] && (rd_q.wraps < WRAP_MAX)) ? rd_q.wraps + 8'd1
                                                                 : rd_q.wraps;
  assign env_prod   = rd_q.env * rd_dec_q;
  assign env_full   = env_prod[47:23];
  assign env_new    = (env_full > {1'b0, ENV_MAX}) ? ENV_MAX : env_full[23:0];
  assign acc_abs    = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign vol_prod   = acc_abs * cfg_i.volume;
  assign played_inc = (played_q == 32'hFFFF_FFFF) ? played_q : played_q + 32'd1;
  assign attack_on  = (cfg_i.attack_periods != 24'd0) && (pos < cfg_i.attack_periods);

  assign pop_o     = (state_q == ST_IDLE) && head_valid_i;
  assign sin_start = (state_q == ST_CHK && bent_q[33:31] == 3'd0) || (state_q == ST_ASTART);
  assign sin_p     = (state_q == ST_ASTART) ? p_att : p_main;

  // A single write port serves both loads and the per-mode writeback of a tick.
  always_comb begin
    mem_we    = 1'b0;
    dec_we    = 1'b0;
    mem_addr  = m_q;
    mem_wdata = '{inc: rd_q.inc, gain: rd_q.gain, phase: phase_sum[31:0],
                  env: env_new, wraps: wraps_new};
    if (pop_o) begin
      mem_addr = head_i.idx;
      mem_wdata = '{inc: head_i.inc, gain: head_i.gain, phase: 32'd0,
                    env: ENV_ONE, wraps: 8'd0};
      case (head_i.kind)
        CMD_LOAD: begin
          mem_we = 1'b1;
          dec_we = 1'b1;
        end
        CMD_DECAY: dec_we = 1'b1;
        default: ;
      endcase
    end else if (state_q == ST_TERM) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mode_mem[mem_addr] <= mem_wdata;
    if (dec_we) decay_mem[mem_addr] <= head_i.decay;
    if (state_q == ST_RD) begin
      rd_q     <= mode_mem[m_q];
      rd_dec_q <= decay_mem[m_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      playing_q <= 1'b0;
      played_q  <= 32'd0;
      strobe_q  <= 1'b0;
      active_q  <= 1'b0;
      sample_q  <= 24'd0;
      m_q       <= '0;
    end else begin
      strobe_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (head_valid_i) begin
            case (head_i.kind)
              CMD_LOAD:  valid_q[head_i.idx] <= 1'b1;
              CMD_DECAY: ;
              CMD_START: begin
                valid_q   <= '0;
                played_q  <= 32'd0;
                playing_q <= 1'b1;
              end
              CMD_STOP: playing_q <= 1'b0;
              CMD_TICK: begin
                if (playing_q) begin
                  m_q     <= '0;
                  state_q <= ST_RD;
                end else begin
                  strobe_q <= 1'b1;
                  sample_q <= 24'd0;
                  active_q <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_RD:   state_q <= valid_q[m_q] ? ST_BEND : ST_NEXT;
        ST_BEND: state_q <= ST_CHK;
        ST_CHK: begin
          // A bent increment at or above half a turn would alias: skip the mode.
          state_q <= (bent_q[33:31] != 3'd0) ? ST_NEXT : ST_SIN;
        end
        ST_SIN: begin
          if (sin_done) state_q <= attack_on ? ST_RATIO : ST_TERM;
        end
        ST_RATIO:  state_q <= ST_ASTART;
        ST_ASTART: state_q <= ST_AWAIT;
        ST_AWAIT: begin
          if (sin_done) state_q <= ST_W2;
        end
        ST_W2:   state_q <= ST_WMUL;
        ST_WMUL: state_q <= ST_TERM;
        ST_TERM: state_q <= ST_NEXT;
        ST_NEXT: begin
          if (m_q == MODE_AW'(MODES - 1)) begin
            state_q <= ST_VOL;
          end else begin
            m_q     <= m_q + 1'b1;
            state_q <= ST_RD;
          end
        end
        ST_VOL: state_q <= ST_OUT;
        ST_OUT: begin
          strobe_q <= 1'b1;
          active_q <= 1'b1;
          if (sneg_q) begin
            sample_q <= (smag_q > (ACC_W + 2)'(24'h80_0000)) ? 24'h80_0000
                                                             : 24'd0 - smag_q[23:0];
          end else begin
            sample_q <= (smag_q > (ACC_W + 2)'(24'h7F_FFFF)) ? 24'h7F_FFFF
                                                             : smag_q[23:0];
          end
          played_q <= played_inc;
          if (played_inc >= cfg_i.duration) playing_q <= 1'b0;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers: each product is taken as a magnitude, with signs tracked aside.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (head_valid_i && head_i.kind == CMD_TICK) begin
          bend_q  <= head_i.bend;
          recip_q <= head_i.recip;
          acc_q   <= '0;
        end
      end
      ST_BEND: bent_q <= bent_prod[49:16];
      ST_CHK: begin
        g_neg_q   <= rd_q.gain[23];
        val_neg_q <= quad[1];
        gm_q      <= cfg_i.gain_by_bend ? gb_prod[41:16] : {2'b00, g_abs};
      end
      ST_SIN: begin
        ge_q <= ge_prod[49:23];
        if (sin_done) sm_q <= sin_value;
      end
      ST_RATIO: begin
        ratio_q <= (ratio_full > {23'd0, ATTACK_ONE}) ? ATTACK_ONE : ratio_full[16:0];
      end
      ST_AWAIT: begin
        if (sin_done) w_q <= sin_value;
      end
      ST_W2:   w2_q <= w2_prod[33:17];
      ST_WMUL: sm_q <= wm_prod[33:17];
      ST_TERM: begin
        if (g_neg_q ^ val_neg_q) acc_q <= acc_q - ACC_W'(term);
        else                     acc_q <= acc_q + ACC_W'(term);
      end
      ST_VOL: begin
        sneg_q <= acc_q[ACC_W-1];
        smag_q <= vol_prod[ACC_W+15:VOL_SHIFT];
      end
      default: ;
    endcase
  end

  assign strobe_o       = strobe_q;
  assign sample_o       = sample_q;
  assign voice_active_o = active_q;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import dsob_pkg::*;

  localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [2:0] OP_RSVD_LAST  = 3'd7;
  localparam int unsigned SETTLE_CYCLES = 600;
  localparam int unsigned TARGET_ITEMS  = 400;

  typedef struct {
    logic [2:0]  op;
    logic [5:0]  idx;
    logic [31:0] inc;
    logic [23:0] gain;
    logic [23:0] dec;
    logic [17:0] bend;
    logic [17:0] rcp;
    bit          pinned;
    logic [23:0] pin_sample;
    bit          pin_active;
  } bank_cmd_t;

  typedef struct {
    logic [23:0] sample;
    logic        active;
  } bank_out_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         opcode_i = OP_TICK;
  logic [5:0]         mode_index_i = '0;
  logic [31:0]        increment_i = '0;
  logic signed [23:0] gain_i = '0;
  logic [23:0]        decay_i = '0;
  logic [17:0]        bend_mult_i = '0;
  logic [17:0]        bend_recip_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_wdata_i = '0;
  logic               result_strobe_o;
  logic signed [23:0] sample_o;
  logic               voice_active_o;

  // Pinned expectations travel with the command so the monitor sees them at acceptance.
  bit          pin_valid = 1'b0;
  logic [23:0] pin_sample = '0;
  bit          pin_active = 1'b0;

  decaying_sine_oscillator_bank_unit dut (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .mode_index_i, .increment_i,
    .gain_i, .decay_i, .bend_mult_i, .bend_recip_i, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_wdata_i, .result_strobe_o, .sample_o, .voice_active_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Shadow state of the bank.
  logic [31:0] sh_phase [MODES];
  logic [31:0] sh_inc [MODES];
  logic [23:0] sh_gain [MODES];
  logic [23:0] sh_decay [MODES];
  logic [23:0] sh_env [MODES];
  logic [7:0]  sh_wraps [MODES];
  bit          sh_valid [MODES];
  logic [31:0] sh_played;
  bit          sh_playing;
  cfg_t        sh_cfg;

  bank_out_t   expected_samples[$];
  bank_cmd_t   dir_rows[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic expect_result(input bank_out_t o);
    expected_samples = {expected_samples, o};
  endtask

  task automatic add_row(input bank_cmd_t c);
    dir_rows = {dir_rows, c};
  endtask

  function automatic longint smul_trunc(input longint a, input longint b, input int sh);
    bit neg;
    longint unsigned ua, ub, p;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = (ua * ub) >> sh;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint quarter_sine(input longint unsigned p);
    longint unsigned divs [6] = '{156, 110, 72, 42, 20, 6};
    longint unsigned x, x2, acc, s, v;
    x = (p * HALF_PI_Q30) >> QTR_W;
    x2 = (x * x) >> 30;
    acc = Q30_ONE;
    for (int k = 0; k < 6; k++) acc = Q30_ONE - ((x2 * acc) >> 30) / divs[k];
    s = (x * acc) >> 30;
    v = (s + 4096) >> 13;
    if (v > SINE_MAX) v = SINE_MAX;
    return longint'(v);
  endfunction

  function automatic longint full_sine(input logic [LUT_AW-1:0] a);
    logic [1:0] q;
    longint unsigned r, v;
    q = a[LUT_AW-1 -: 2];
    r = a[QTR_W-1:0];
    v = quarter_sine(q[0] ? (longint'(1) << QTR_W) - r : r);
    return q[1] ? -longint'(v) : longint'(v);
  endfunction

  function automatic bank_out_t mix_tick(input logic [17:0] bend, input logic [17:0] rcp);
    bank_out_t o;
    longint acc, g, value, w, w2, s;
    longint unsigned bent, pos, ratio, env;
    logic [31:0] nxt;
    acc = 0;
    if (!sh_playing) begin
      o.sample = '0;
      o.active = 1'b0;
      return o;
    end
    for (int m = 0; m < MODES; m++) begin
      if (!sh_valid[m]) continue;
      bent = (longint'(sh_inc[m]) * bend) >> 16;
      if (bent >= 64'h8000_0000) continue;
      g = longint'(signed'(sh_gain[m]));
      if (sh_cfg.gain_by_bend) g = smul_trunc(g, longint'(rcp), 16);
      value = full_sine(sh_phase[m][31 -: LUT_AW]);
      if (sh_cfg.attack_periods != 0) begin
        pos = {sh_wraps[m], sh_phase[m][31:16]};
        if (pos < sh_cfg.attack_periods) begin
          ratio = (pos * sh_cfg.attack_recip) >> 16;
          if (ratio > ATTACK_ONE) ratio = ATTACK_ONE;
          w = quarter_sine(ratio);
          w2 = (w * w) >>> 17;
          value = smul_trunc(value, w2, 17);
        end
      end
      acc += smul_trunc(smul_trunc(g, longint'(sh_env[m]), 23), value, 17);
      nxt = sh_phase[m] + bent[31:0];
      if (nxt < sh_phase[m] && sh_wraps[m] < WRAP_MAX) sh_wraps[m]++;
      sh_phase[m] = nxt;
      env = (longint'(sh_env[m]) * sh_decay[m]) >> 23;
      sh_env[m] = (env > ENV_MAX) ? ENV_MAX : env[23:0];
    end
    s = smul_trunc(acc, longint'(sh_cfg.volume), VOL_SHIFT);
    if (s > 8388607) s = 8388607;
    if (s < -8388608) s = -8388608;
    o.sample = s[23:0];
    o.active = 1'b1;
    if (sh_played != 32'hFFFF_FFFF) sh_played++;
    if (sh_played >= sh_cfg.duration) sh_playing = 1'b0;
    return o;
  endfunction

  // Command acceptance: update the shadow bank and queue what the tick should produce.
  always @(posedge clk_i) begin
    bank_out_t o;
    if (rst_ni && start && !busy) begin
      case (opcode_i)
        OP_LOAD, OP_DECAY: begin
          sh_decay[mode_index_i] = decay_i;
          if (opcode_i == OP_LOAD) begin
            sh_inc[mode_index_i] = increment_i;
            sh_gain[mode_index_i] = gain_i;
            sh_phase[mode_index_i] = '0;
            sh_wraps[mode_index_i] = '0;
            sh_env[mode_index_i] = ENV_ONE;
            sh_valid[mode_index_i] = 1'b1;
          end
        end
        OP_START: begin
          for (int m = 0; m < MODES; m++) sh_valid[m] = 1'b0;
          sh_played = '0;
          sh_playing = 1'b1;
        end
        OP_STOP: sh_playing = 1'b0;
        OP_TICK: begin
          o = mix_tick(bend_mult_i, bend_recip_i);
          if (pin_valid) begin
            o.sample = pin_sample;
            o.active = pin_active;
          end
          expect_result(o);
        end
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    bank_out_t want;
    if (rst_ni && result_strobe_o) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected sample", sample_o, '0);
      end else begin
        want = expected_samples.pop_front();
        if (sample_o !== want.sample) report_mismatch("sample", sample_o, want.sample);
        if (voice_active_o !== want.active)
          report_mismatch("voice_active", 24'(voice_active_o), 24'(want.active));
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 120);
  endfunction

  task automatic send_cmd(input bank_cmd_t c);
    int unsigned gap;
    opcode_i <= c.op;
    mode_index_i <= c.idx;
    increment_i <= c.inc;
    gain_i <= c.gain;
    decay_i <= c.dec;
    bend_mult_i <= c.bend;
    bend_recip_i <= c.rcp;
    pin_valid <= c.pinned;
    pin_sample <= c.pin_sample;
    pin_active <= c.pin_active;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_bank();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (index)
      CFG_VOLUME:   sh_cfg.volume = data[15:0];
      CFG_ATT_LEN:  sh_cfg.attack_periods = data[23:0];
      CFG_ATT_RCP:  sh_cfg.attack_recip = data;
      CFG_DURATION: sh_cfg.duration = data;
      CFG_GAIN_BND: sh_cfg.gain_by_bend = data[0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] vol, input logic [23:0] alen,
                           input logic [31:0] arcp, input logic [31:0] dur, input bit gbb);
    write_reg(CFG_VOLUME, 32'(vol));
    write_reg(CFG_ATT_LEN, 32'(alen));
    write_reg(CFG_ATT_RCP, arcp);
    write_reg(CFG_DURATION, dur);
    write_reg(CFG_GAIN_BND, 32'(gbb));
  endtask

  function automatic bank_cmd_t mk(input logic [2:0] op, input logic [5:0] idx,
                                   input logic [31:0] inc, input logic [23:0] gain,
                                   input logic [23:0] dec, input logic [17:0] bend,
                                   input logic [17:0] rcp);
    bank_cmd_t c;
    c = '{op, idx, inc, gain, dec, bend, rcp, 1'b0, '0, 1'b0};
    return c;
  endfunction

  function automatic bank_cmd_t pin(input bank_cmd_t c, input logic [23:0] s, input bit a);
    c.pinned = 1'b1;
    c.pin_sample = s;
    c.pin_active = a;
    return c;
  endfunction

  function automatic bank_cmd_t rand_cmd(input logic [2:0] op);
    bank_cmd_t c;
    c = mk(op, 6'($urandom_range(0, MODES - 1)), $urandom, 24'($urandom),
           24'($urandom_range(0, 8388608)), 18'($urandom), 18'($urandom));
    if ($urandom_range(0, 3) != 0) c.bend = 18'($urandom_range(18'h0C000, 18'h14000));
    if ($urandom_range(0, 2) != 0) c.inc = $urandom_range(0, 32'h0800_0000);
    if ($urandom_range(0, 9) == 0) c.dec = ENV_ONE;
    return c;
  endfunction

  task automatic play_note();
    int unsigned n, ticks;
    bank_cmd_t c;
    bit big;
    big = ($urandom_range(0, 24) == 0);
    if ($urandom_range(0, 7) != 0) send_cmd(rand_cmd(OP_START));
    n = big ? MODES : $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      c = rand_cmd(OP_LOAD);
      if (big) c.idx = 6'(i);
      send_cmd(c);
    end
    ticks = big ? 2 : $urandom_range(1, 8);
    for (int t = 0; t < ticks; t++) begin
      case ($urandom_range(0, 11))
        0: send_cmd(rand_cmd(OP_DECAY));
        1: send_cmd(rand_cmd(3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST))));
        2: send_cmd(rand_cmd(OP_STOP));
        default: ;
      endcase
      send_cmd(rand_cmd(OP_TICK));
    end
  endtask

  initial begin
    for (int m = 0; m < MODES; m++) begin
      sh_phase[m] = '0;
      sh_env[m] = ENV_ONE;
      sh_wraps[m] = '0;
      sh_valid[m] = 1'b0;
    end
    sh_played = '0;
    sh_playing = 1'b0;
    sh_cfg = '{16'd32768, 24'd0, 32'd0, 32'd0, 1'b0};

    #1 rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With a zero duration a note lasts for exactly one tick.
    add_row(pin(mk(OP_TICK, '0, '0, '0, '0, '0, '0), '0, 1'b0));
    add_row(mk(OP_START, '0, '0, '0, '0, '0, '0));
    add_row(pin(mk(OP_TICK, '0, '0, '0, '0, 18'h10000, '0), '0, 1'b1));
    add_row(pin(mk(OP_TICK, '0, '0, '0, '0, 18'h10000, '0), '0, 1'b0));
    add_row(mk(OP_RSVD_FIRST, '0, '1, '1, '1, '1, '1));
    add_row(mk(OP_RSVD_LAST, 6'd63, '1, '1, '1, '1, '1));
    add_row(mk(OP_STOP, '0, '0, '0, '0, '0, '0));
    foreach (dir_rows[i]) send_cmd(dir_rows[i]);
    drain_bank();
    write_all(16'hFFFF, 24'h020000, 32'h0000_8000, 32'hFFFF_FFFF, 1'b1);

    dir_rows.delete();
    add_row(mk(OP_START, '0, '0, '0, '0, '0, '0));
    // A freshly loaded mode sits at phase zero, so its first sine value is zero.
    add_row(mk(OP_LOAD, '0, 32'h1000_0000, 24'h7FFFFF, ENV_ONE, '0, '0));
    add_row(pin(mk(OP_TICK, '0, '0, '0, '0, 18'h10000, 18'h10000), '0, 1'b1));
    add_row(mk(OP_LOAD, 6'd63, 32'hFFFF_FFFF, 24'h800000, 24'd0, '0, '0));
    add_row(mk(OP_LOAD, 6'd1, 32'h0800_0000, 24'h800000, 24'h800000, '0, '0));
    add_row(mk(OP_DECAY, 6'd1, '0, '0, 24'h7FFFFF, '0, '0));
    add_row(mk(OP_TICK, 6'd5, '1, '1, '1, 18'h10000, 18'h3FFFF));
    add_row(mk(OP_TICK, '0, '0, '0, '0, 18'h3FFFF, 18'h00000));
    add_row(mk(OP_TICK, '0, '0, '0, '0, 18'h00000, 18'h10000));
    for (int i = 0; i < 4; i++)
      add_row(mk(OP_TICK, '0, '0, '0, '0, 18'h10000, 18'h08000));
    add_row(mk(OP_STOP, '0, '0, '0, '0, '0, '0));
    add_row(pin(mk(OP_TICK, '0, '0, '0, '0, 18'h10000, '0), '0, 1'b0));
    add_row(mk(OP_START, '0, '0, '0, '0, '0, '0));
    add_row(pin(mk(OP_TICK, '0, '0, '0, '0, 18'h10000, '0), '0, 1'b1));
    foreach (dir_rows[i]) send_cmd(dir_rows[i]);
    drain_bank();

    while (items_sent < TARGET_ITEMS) begin
      case ($urandom_range(0, 3))
        0: write_all('0, '0, '0, 32'($urandom_range(1, 10)), 1'b0);
        1: write_all(16'hFFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        default: write_all(16'($urandom), 24'($urandom_range(0, 24'h030000)), $urandom,
                           ($urandom_range(0, 1) != 0) ? $urandom_range(1, 12) : $urandom,
                           1'($urandom_range(0, 1)));
      endcase
      for (int k = 0; k < 4; k++) play_note();
      drain_bank();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
